### rtl/core/bml_pkg.sv
// Package of the bracket matching lexer: payload types, token and status codes,
// character constants and the command decoder. Depends on nothing.
package bml_pkg;

  localparam int BML_STACK_DEPTH = 256;
  localparam int BML_INDEX_BITS  = 16;

  localparam logic [2:0] KIND_INC    = 3'd0;
  localparam logic [2:0] KIND_DEC    = 3'd1;
  localparam logic [2:0] KIND_RIGHT  = 3'd2;
  localparam logic [2:0] KIND_LEFT   = 3'd3;
  localparam logic [2:0] KIND_OPEN   = 3'd4;
  localparam logic [2:0] KIND_CLOSE  = 3'd5;
  localparam logic [2:0] KIND_OUTPUT = 3'd6;
  localparam logic [2:0] KIND_INPUT  = 3'd7;

  localparam logic [1:0] ST_OK       = 2'd0;
  localparam logic [1:0] ST_EXTRA    = 2'd1;
  localparam logic [1:0] ST_MISSING  = 2'd2;
  localparam logic [1:0] ST_CAPACITY = 2'd3;

  localparam logic [7:0] CH_PLUS    = 8'h2B;
  localparam logic [7:0] CH_MINUS   = 8'h2D;
  localparam logic [7:0] CH_GREATER = 8'h3E;
  localparam logic [7:0] CH_LESS    = 8'h3C;
  localparam logic [7:0] CH_LBRACK  = 8'h5B;
  localparam logic [7:0] CH_RBRACK  = 8'h5D;
  localparam logic [7:0] CH_DOT     = 8'h2E;
  localparam logic [7:0] CH_COMMA   = 8'h2C;
  localparam logic [7:0] CH_NEWLINE = 8'h0A;

  localparam logic [15:0] POS_MAX = 16'hFFFF;

  typedef struct packed {
    logic [7:0] char_byte;
    logic       end_of_program;
  } item_t;

  typedef struct packed {
    logic [2:0]  token_kind;
    logic [15:0] token_index;
    logic [15:0] line_number;
    logic [15:0] column_number;
    logic [15:0] partner_index;
    logic        partner_valid;
    logic [1:0]  status;
    logic        done_res;
    logic [16:0] token_total;
  } result_t;

  typedef struct packed {
    logic       hit;
    logic [2:0] kind;
  } decode_t;

  function automatic decode_t decode_char(input logic [7:0] b);
    decode_t d;
    d.hit  = 1'b1;
    d.kind = KIND_INC;
    unique case (b)
      CH_PLUS:    d.kind = KIND_INC;
      CH_MINUS:   d.kind = KIND_DEC;
      CH_GREATER: d.kind = KIND_RIGHT;
      CH_LESS:    d.kind = KIND_LEFT;
      CH_LBRACK:  d.kind = KIND_OPEN;
      CH_RBRACK:  d.kind = KIND_CLOSE;
      CH_DOT:     d.kind = KIND_OUTPUT;
      CH_COMMA:   d.kind = KIND_INPUT;
      default:    d.hit  = 1'b0;
    endcase
    return d;
  endfunction

endpackage

### rtl/core/bml_if.sv
// Request channels of the bracket matching lexer: program bytes in, tokens out.
// Depends on bml_pkg for the payload types.
interface bml_in_if import bml_pkg::*; ();
  logic  valid;
  logic  ready;
  item_t payload;
  modport source (output valid, output payload, input ready);
  modport sink (input valid, input payload, output ready);
endinterface

interface bml_out_if import bml_pkg::*; ();
  logic    valid;
  logic    ready;
  result_t payload;
  modport source (output valid, output payload, input ready);
  modport sink (input valid, input payload, output ready);
endinterface

### rtl/core/bracket_matching_token_lexer.sv
// Top level of the bracket matching lexer: core, stack memory and output stage.
// Depends on bml_pkg, bml_if, bml_stack, bml_skid and bml_core.
//
//   channel   direction  payload
//   byte_ch   in         char_byte, end_of_program
//   token_ch  out        token and end results
//
// One byte is taken every cycle while the output stage has room; a push or pop is one stack access per cycle.
// The top entry sits in a register and the memory read port always holds the
// entry below it, so consecutive pops and pushes need no interlock.
// A result is registered in the output stage before it appears on token_ch.
// Bytes are held off only when both output entries are full.
// Reset is synchronous; the stack memory is not cleared.
module bracket_matching_token_lexer import bml_pkg::*; #(
  parameter int STACK_DEPTH = BML_STACK_DEPTH,
  parameter int INDEX_BITS  = BML_INDEX_BITS
) (
  input  logic      clk,
  input  logic      rst,
  bml_in_if.sink    byte_ch,
  bml_out_if.source token_ch
);

  localparam int AW = (STACK_DEPTH > 1) ? $clog2(STACK_DEPTH) : 1;
  localparam int EW = INDEX_BITS + 32;

  logic          space;
  logic          accept;
  logic          res_valid;
  result_t       res;
  logic          wr_en;
  logic [AW-1:0] wr_addr;
  logic [EW-1:0] wr_data;
  logic [AW-1:0] rd_addr;
  logic [EW-1:0] rd_data;

  assign byte_ch.ready = space;
  assign accept        = byte_ch.valid & space;

  bml_core #(
    .STACK_DEPTH (STACK_DEPTH),
    .INDEX_BITS  (INDEX_BITS),
    .AW          (AW),
    .EW          (EW)
  ) u_core (
    .clk       (clk),
    .rst       (rst),
    .accept    (accept),
    .item      (byte_ch.payload),
    .res_valid (res_valid),
    .res       (res),
    .wr_en     (wr_en),
    .wr_addr   (wr_addr),
    .wr_data   (wr_data),
    .rd_addr   (rd_addr),
    .rd_data   (rd_data)
  );

  bml_stack #(
    .DEPTH (STACK_DEPTH),
    .WIDTH (EW),
    .AW    (AW)
  ) u_stack (
    .clk     (clk),
    .wr_en   (wr_en),
    .wr_addr (wr_addr),
    .wr_data (wr_data),
    .rd_addr (rd_addr),
    .rd_data (rd_data)
  );

  bml_skid u_skid (
    .clk       (clk),
    .rst       (rst),
    .res_valid (res_valid),
    .res       (res),
    .space     (space),
    .token_ch  (token_ch)
  );

endmodule

### rtl/core/bml_stack.sv
// Open bracket stack memory: one write port, one registered read port.
// Depends on nothing.
module bml_stack #(
  parameter int DEPTH = 256,
  parameter int WIDTH = 48,
  parameter int AW    = 8
) (
  input  logic             clk,
  input  logic             wr_en,
  input  logic [AW-1:0]    wr_addr,
  input  logic [WIDTH-1:0] wr_data,
  input  logic [AW-1:0]    rd_addr,
  output logic [WIDTH-1:0] rd_data
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    rd_data <= mem[rd_addr];
  end

endmodule

### rtl/core/bml_skid.sv
// Two-entry output stage that parts the lexer from the token channel.
// Depends on bml_pkg and bml_out_if.
module bml_skid import bml_pkg::*; (
  input  logic              clk,
  input  logic              rst,
  input  logic              res_valid,
  input  result_t           res,
  output logic              space,
  bml_out_if.source         token_ch
);

  logic    out_valid;
  result_t out_data;
  logic    skid_valid;
  result_t skid_data;
  logic    out_fire;

  assign out_fire         = out_valid & token_ch.ready;
  assign space            = ~skid_valid;
  assign token_ch.valid   = out_valid;
  assign token_ch.payload = out_data;

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid  <= 1'b0;
      skid_valid <= 1'b0;
    end else if (res_valid) begin
      if (!out_valid || out_fire) begin
        out_valid <= 1'b1;
      end else begin
        skid_valid <= 1'b1;
      end
    end else if (out_fire) begin
      out_valid  <= skid_valid;
      skid_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (res_valid) begin
      if (!out_valid || out_fire) begin
        out_data <= res;
      end else begin
        skid_data <= res;
      end
    end else if (out_fire && skid_valid) begin
      out_data <= skid_data;
    end
  end

endmodule

### rtl/core/bml_core.sv
// Lexer state and token logic: position tracking, token numbering and bracket
// matching against the stack memory. Depends on bml_pkg.
module bml_core import bml_pkg::*; #(
  parameter int STACK_DEPTH = BML_STACK_DEPTH,
  parameter int INDEX_BITS  = BML_INDEX_BITS,
  parameter int AW          = 8,
  parameter int EW          = INDEX_BITS + 32
) (
  input  logic          clk,
  input  logic          rst,
  input  logic          accept,
  input  item_t         item,
  output logic          res_valid,
  output result_t       res,
  output logic          wr_en,
  output logic [AW-1:0] wr_addr,
  output logic [EW-1:0] wr_data,
  output logic [AW-1:0] rd_addr,
  input  logic [EW-1:0] rd_data
);

  localparam int SPW = $clog2(STACK_DEPTH + 1);
  localparam int CW  = INDEX_BITS + 1;
  localparam logic [SPW-1:0] SP_FULL = SPW'(STACK_DEPTH);

  logic [SPW-1:0]        sp, sp_next;
  logic [CW-1:0]         counter, counter_next;
  logic [15:0]           line, line_next;
  logic [15:0]           col, col_next;
  logic [1:0]            err, err_next;
  logic [31:0]           err_loc, err_loc_next;
  logic [EW-1:0]         top, top_next;

  decode_t               dec;
  logic [15:0]           col_adv;
  logic [SPW-1:0]        rd_ptr;
  logic [INDEX_BITS+15:0] cur_idx_ext;
  logic [INDEX_BITS+15:0] top_idx_ext;
  logic [CW+16:0]        total_ext;

  assign dec         = decode_char(item.char_byte);
  assign col_adv     = (col != POS_MAX) ? col + 16'd1 : col;
  assign cur_idx_ext = {16'b0, counter[INDEX_BITS-1:0]};
  assign top_idx_ext = {16'b0, top[EW-1:32]};
  assign total_ext   = {17'b0, counter};
  assign rd_ptr      = sp_next - SPW'(2);
  assign rd_addr     = rd_ptr[AW-1:0];
  assign wr_addr     = sp[AW-1:0];
  assign wr_data     = {counter[INDEX_BITS-1:0], line, col};

  always_comb begin
    sp_next      = sp;
    counter_next = counter;
    line_next    = line;
    col_next     = col;
    err_next     = err;
    err_loc_next = err_loc;
    top_next     = top;
    wr_en        = 1'b0;
    res_valid    = 1'b0;
    res          = '0;
    if (accept) begin
      if (item.end_of_program) begin
        res_valid         = 1'b1;
        res.done_res      = 1'b1;
        res.token_total   = total_ext[16:0];
        res.status        = err;
        if (err != ST_OK) begin
          res.line_number   = err_loc[31:16];
          res.column_number = err_loc[15:0];
        end else if (sp != '0) begin
          res.status        = ST_MISSING;
          res.token_index   = top_idx_ext[15:0];
          res.line_number   = top[31:16];
          res.column_number = top[15:0];
        end else begin
          res.line_number   = line;
          res.column_number = col;
        end
        sp_next      = '0;
        counter_next = '0;
        line_next    = 16'd1;
        col_next     = 16'd1;
        err_next     = ST_OK;
        err_loc_next = '0;
      end else if (err != ST_OK) begin
        res_valid = 1'b0;
      end else if (item.char_byte == CH_NEWLINE) begin
        line_next = (line != POS_MAX) ? line + 16'd1 : line;
        col_next  = 16'd1;
      end else if (!dec.hit) begin
        col_next = col_adv;
      end else begin
        res_valid         = 1'b1;
        res.token_kind    = dec.kind;
        res.line_number   = line;
        res.column_number = col;
        col_next          = col_adv;
        if (counter[INDEX_BITS]) begin
          err_next     = ST_CAPACITY;
          err_loc_next = {line, col};
          res.status   = ST_CAPACITY;
        end else begin
          res.token_index = cur_idx_ext[15:0];
          counter_next    = counter + CW'(1);
          if (dec.kind == KIND_OPEN) begin
            if (sp == SP_FULL) begin
              err_next     = ST_CAPACITY;
              err_loc_next = {line, col};
              res.status   = ST_CAPACITY;
              counter_next = counter;
            end else begin
              wr_en    = 1'b1;
              top_next = wr_data;
              sp_next  = sp + SPW'(1);
            end
          end else if (dec.kind == KIND_CLOSE) begin
            if (sp == '0) begin
              err_next     = ST_EXTRA;
              err_loc_next = {line, col};
              res.status   = ST_EXTRA;
            end else begin
              res.partner_index = top_idx_ext[15:0];
              res.partner_valid = 1'b1;
              top_next          = rd_data;
              sp_next           = sp - SPW'(1);
            end
          end
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      sp      <= '0;
      counter <= '0;
      line    <= 16'd1;
      col     <= 16'd1;
      err     <= ST_OK;
      err_loc <= '0;
    end else begin
      sp      <= sp_next;
      counter <= counter_next;
      line    <= line_next;
      col     <= col_next;
      err     <= err_next;
      err_loc <= err_loc_next;
    end
  end

  always_ff @(posedge clk) begin
    top <= top_next;
  end

endmodule
